FILE: sv/gbrs_pkg.sv
// ----------------------------------------------------------------------------
// Grid keypoint index package
// Shared types, command and status codes, and the cell-bound conversion used
// by the front and back ends of the grid bucketed radius search block.
// ----------------------------------------------------------------------------
package gbrs_pkg;

  // Fixed field widths
  localparam int CW_W   = 16;   // coordinate width, Q12.4
  localparam int IDX_W  = 10;   // width of the result index field
  localparam int FRAC   = 20;   // fraction bits of a scaled offset
  localparam int PW     = 35;   // scaled offset width
  localparam int BW     = 15;   // signed cell bound width

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_FILED   = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_NOHITS  = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // Register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_INV_CW   = 2'd2;
  localparam logic [1:0] REG_INV_CH   = 2'd3;

  localparam logic [15:0] INV_RESET = 16'd6554;

  // Rounding modes of a scaled offset
  typedef enum logic [1:0] {
    CV_FLOOR = 2'd0,
    CV_CEIL  = 2'd1,
    CV_ROUND = 2'd2
  } conv_mode_t;

  // Configuration registers
  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        inv_cw;
    logic [15:0]        inv_ch;
  } cfg_t;

  // One classified command between the front and back ends
  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic [2:0]          oct;
    logic [14:0]         radius;
    logic [2:0]          min_level;
    logic signed [3:0]   max_level;
    logic signed [BW-1:0] bx0;
    logic signed [BW-1:0] bx1;
    logic signed [BW-1:0] by0;
    logic signed [BW-1:0] by1;
  } job_t;

  // Turn a scaled Q.20 offset into a cell number.
  function automatic logic signed [BW-1:0] cell_conv(input logic signed [PW-1:0] p,
                                                    input conv_mode_t m);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] mag;
    logic signed [PW-1:0] ceil_add;
    logic signed [PW-1:0] half;
    t        = '0;
    mag      = '0;
    ceil_add = PW'((64'd1 << FRAC) - 64'd1);
    half     = PW'(64'd1 << (FRAC - 1));
    case (m)
      CV_FLOOR: t = p >>> FRAC;
      CV_CEIL:  t = (p + ceil_add) >>> FRAC;
      default: begin
        if (!p[PW-1]) begin
          t = (p + half) >>> FRAC;
        end else begin
          mag = -p;
          t   = -((mag + half) >>> FRAC);
        end
      end
    endcase
    return t[BW-1:0];
  endfunction

endpackage

FILE: sv/grid_bucketed_radius_search.sv
// ----------------------------------------------------------------------------
// Grid bucketed radius search
// Keypoint grid index: clear, insert and rectangular radius query.
// ----------------------------------------------------------------------------
// Input beats carry a command (clear, insert, query) with its point, radius
// and level window; a beat is taken when in_valid is high and in_stall low.
// Each command gives one or more result beats on the out_ channel, taken when
// out_valid is high and out_stall low; out_last marks the final one.
// The cfg_ channel writes origin and inverse cell size registers and is
// always ready; the user must see that it is written only while the block
// is idle, as the block itself does not enforce this. An insert's result
// beat follows its input beat through the front end, where one shared
// multiplier scales four offsets in turn, then through the queue and a
// read-modify-write of the cell memory (none for a point outside the grid).
// The front end takes no new beat after an insert or query until it has
// pushed that command into the queue. A query visits each grid cell in its
// window and walks each listed point.
// A clear sweeps the cell memory, one cell per cycle, then reports. After reset
// the same sweep runs and in_stall stays high until it ends. A stalled result
// holds in the output register while the front end keeps taking beats into the
// two-entry queue.
// ----------------------------------------------------------------------------
module grid_bucketed_radius_search import gbrs_pkg::*; #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 48,
  parameter int MAX_POINTS = 1024,
  parameter int MAX_HITS   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [2:0]         in_octave,
  input  logic [14:0]        in_radius,
  input  logic [2:0]         in_min_level,
  input  logic signed [3:0]  in_max_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [9:0]         out_point_index,
  output logic               out_truncated,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty, init_busy;
  job_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.inv_cw   <= INV_RESET;
      cfg_r.inv_ch   <= INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: cfg_r.origin_x <= cfg_data;
        REG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
        REG_INV_CW:   cfg_r.inv_cw   <= cfg_data;
        REG_INV_CH:   cfg_r.inv_ch   <= cfg_data;
        default:      cfg_r.inv_ch   <= cfg_r.inv_ch;
      endcase
    end
  end

  gbrs_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_octave(in_octave),
    .in_radius(in_radius), .in_min_level(in_min_level), .in_max_level(in_max_level),
    .init_busy(init_busy), .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  gbrs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  gbrs_back #(
    .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS),
    .MAX_POINTS(MAX_POINTS), .MAX_HITS(MAX_HITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .init_busy(init_busy), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_point_index(out_point_index),
    .out_truncated(out_truncated), .out_last(out_last)
  );

`ifndef SYNTHESIS
  // No input beat is taken while the reset sweep runs.
  a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> in_stall) else $error("input taken during reset sweep");

  // The front end never pushes into a full queue.
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue overflow");

  // The back end never pops an empty queue.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue underflow");
`endif

endmodule

FILE: sv/gbrs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gbrs_front.sv
// ----------------------------------------------------------------------------
// Grid index front end
// Accepts input beats, scales the point offsets by the inverse cell size with
// one shared multiplier and pushes each clear, insert or query to the queue.
// ----------------------------------------------------------------------------
module gbrs_front import gbrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [2:0]         in_octave,
  input  logic [14:0]        in_radius,
  input  logic [2:0]         in_min_level,
  input  logic signed [3:0]  in_max_level,
  input  logic               init_busy,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t              st_r, st_nxt;
  job_t                 job_r, job_nxt;
  logic [2:0]           step_r, step_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;

  logic signed [16:0]   dx, dy;
  logic signed [17:0]   rr, a_op;
  logic signed [16:0]   inv_s;
  logic [1:0]           cidx;
  conv_mode_t           cmode;
  logic signed [BW-1:0] bval;

  assign in_stall = (st_r != F_IDLE) || init_busy;
  assign q_data   = job_r;

  // Operand selection for the shared multiplier
  always_comb begin
    dx    = {job_r.x[15], job_r.x} - {cfg.origin_x[15], cfg.origin_x};
    dy    = {job_r.y[15], job_r.y} - {cfg.origin_y[15], cfg.origin_y};
    rr    = (job_r.cmd == CMD_QUERY) ? $signed({3'b000, job_r.radius}) : '0;
    case (step_r[1:0])
      2'd0:    a_op = {dx[16], dx} - rr;
      2'd1:    a_op = {dx[16], dx} + rr;
      2'd2:    a_op = {dy[16], dy} - rr;
      default: a_op = {dy[16], dy} + rr;
    endcase
    inv_s = $signed({1'b0, (step_r[1] ? cfg.inv_ch : cfg.inv_cw)});
    cidx  = 2'(step_r - 3'd1);
    if (job_r.cmd == CMD_INSERT) begin
      cmode = CV_ROUND;
    end else begin
      cmode = cidx[0] ? CV_CEIL : CV_FLOOR;
    end
    bval = cell_conv(prod_r, cmode);
  end

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    job_nxt  = job_r;
    step_nxt = step_r;
    prod_nxt = prod_r;
    q_push   = 1'b0;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid && !in_stall) begin
          job_nxt.cmd       = in_cmd;
          job_nxt.x         = in_point_x;
          job_nxt.y         = in_point_y;
          job_nxt.oct       = in_octave;
          job_nxt.radius    = in_radius;
          job_nxt.min_level = in_min_level;
          job_nxt.max_level = in_max_level;
          step_nxt          = '0;
          case (in_cmd)
            CMD_CLEAR:              st_nxt = F_PUSH;
            CMD_INSERT, CMD_QUERY:  st_nxt = F_CALC;
            default:                st_nxt = F_IDLE;
          endcase
        end
      end
      F_CALC: begin
        prod_nxt = PW'(a_op) * PW'(inv_s);
        if (step_r != 3'd0) begin
          case (cidx)
            2'd0:    job_nxt.bx0 = bval;
            2'd1:    job_nxt.bx1 = bval;
            2'd2:    job_nxt.by0 = bval;
            default: job_nxt.by1 = bval;
          endcase
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    prod_r <= prod_nxt;
  end

endmodule

FILE: sv/gbrs_queue.sv
// ----------------------------------------------------------------------------
// Grid index command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module gbrs_queue import gbrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/gbrs_back.sv
// ----------------------------------------------------------------------------
// Grid index back end
// Executes clear, insert and query commands against the point and cell
// memories, walks cell lists and drives the result register.
// ----------------------------------------------------------------------------
module gbrs_back import gbrs_pkg::*; #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 48,
  parameter int MAX_POINTS = 1024,
  parameter int MAX_HITS   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [9:0] out_point_index,
  output logic       out_truncated,
  output logic       out_last
);

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int NCELL = GRID_COLS * GRID_ROWS;
  localparam int NCW   = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int HW    = $clog2(MAX_HITS + 1);
  localparam int PTW   = 2 * CW_W + 3;
  localparam int CLW   = 2 * IW + 1;
  localparam logic signed [BW-1:0] COLS_S = BW'(GRID_COLS);
  localparam logic signed [BW-1:0] ROWS_S = BW'(GRID_ROWS);

  typedef enum logic [6:0] {
    B_SWEEP  = 7'b0000001,
    B_IDLE   = 7'b0000010,
    B_INS    = 7'b0000100,
    B_QCELL  = 7'b0001000,
    B_QCWAIT = 7'b0010000,
    B_QPT    = 7'b0100000,
    B_QEND   = 7'b1000000
  } bstate_t;

  bstate_t           st_r, st_nxt;
  logic              clr_r, clr_nxt;
  logic [NCW-1:0]    sweep_r, sweep_nxt;
  logic [IW:0]       count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [NCW-1:0]    caddr_r, caddr_nxt;
  logic signed [15:0] x_r, x_nxt, y_r, y_nxt;
  logic [14:0]       rad_r, rad_nxt;
  logic [2:0]        minl_r, minl_nxt;
  logic signed [3:0] maxl_r, maxl_nxt;
  logic [CW-1:0]     ix_r, ix_nxt, x1_r, x1_nxt;
  logic [RW-1:0]     iy_r, iy_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [IW-1:0]     p_r, p_nxt, tail_r, tail_nxt, pend_r, pend_nxt;
  logic [HW-1:0]     n_r, n_nxt;
  logic              trunc_r, trunc_nxt, pend_v_r, pend_v_nxt;
  logic              out_v_r;
  logic [2:0]        out_st_r;
  logic [9:0]        out_idx_r;
  logic              out_tr_r, out_last_r;

  // Memory ports
  logic              pt_we, nx_we, cl_we;
  logic [IW-1:0]     pt_raddr, nx_waddr;
  logic [NCW-1:0]    cl_waddr, cl_raddr;
  logic [PTW-1:0]    pt_wdata, pt_rdata;
  logic [IW-1:0]     nx_rdata;
  logic [CLW-1:0]    cl_wdata, cl_rdata;

  // Emit request toward the result register
  logic              out_free, emit, e_trunc, e_last, adv;
  logic [2:0]        e_status;
  logic [IW-1:0]     e_idx;

  // Decoded values
  logic              ins_ok, q_empty_rng, c_used, qual, lvl_ok;
  logic [NCW-1:0]    ins_addr, q_addr;
  logic [IW-1:0]     c_head, c_tail;
  logic signed [15:0] sx, sy;
  logic [2:0]        so;
  logic signed [16:0] ddx, ddy;
  logic [16:0]       adx, ady;
  logic [CW-1:0]     qx0, qx1;
  logic [RW-1:0]     qy0, qy1;

  gbrs_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(count_r[IW-1:0]), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  gbrs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_nx_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(idx_r),
    .raddr(pt_raddr), .rdata(nx_rdata)
  );

  gbrs_ram #(.WIDTH(CLW), .DEPTH(NCELL)) u_cl_ram (
    .clk(clk), .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
    .raddr(cl_raddr), .rdata(cl_rdata)
  );

  assign init_busy       = (st_r == B_SWEEP) && !clr_r;
  assign out_free        = !out_v_r || !out_stall;
  assign out_valid       = out_v_r;
  assign out_status      = out_st_r;
  assign out_point_index = out_idx_r;
  assign out_truncated   = out_tr_r;
  assign out_last        = out_last_r;
  assign pt_wdata        = {q_data.x, q_data.y, q_data.oct};

  // Cell ranges and addresses
  always_comb begin
    ins_ok = (q_data.bx0 >= 0) && (q_data.bx0 < COLS_S) &&
             (q_data.by0 >= 0) && (q_data.by0 < ROWS_S);
    ins_addr = NCW'(q_data.bx0[CW-1:0]) * NCW'(GRID_ROWS) + NCW'(q_data.by0[RW-1:0]);
    q_empty_rng = !((q_data.bx0 < COLS_S) && (q_data.bx1 >= 0) &&
                    (q_data.by0 < ROWS_S) && (q_data.by1 >= 0));
    qx0 = (q_data.bx0 < 0) ? '0 : q_data.bx0[CW-1:0];
    qx1 = (q_data.bx1 > COLS_S - 1) ? CW'(GRID_COLS - 1) : q_data.bx1[CW-1:0];
    qy0 = (q_data.by0 < 0) ? '0 : q_data.by0[RW-1:0];
    qy1 = (q_data.by1 > ROWS_S - 1) ? RW'(GRID_ROWS - 1) : q_data.by1[RW-1:0];
    q_addr = NCW'(ix_r) * NCW'(GRID_ROWS) + NCW'(iy_r);
    c_used = cl_rdata[2*IW];
    c_head = cl_rdata[2*IW-1:IW];
    c_tail = cl_rdata[IW-1:0];
  end

  // Hit test of the point just read
  always_comb begin
    sx     = pt_rdata[PTW-1:CW_W+3];
    sy     = pt_rdata[CW_W+2:3];
    so     = pt_rdata[2:0];
    ddx    = {sx[15], sx} - {x_r[15], x_r};
    ddy    = {sy[15], sy} - {y_r[15], y_r};
    adx    = ddx[16] ? 17'(-ddx) : 17'(ddx);
    ady    = ddy[16] ? 17'(-ddy) : 17'(ddy);
    lvl_ok = (so >= minl_r) && (maxl_r[3] || (so <= maxl_r[2:0]));
    qual   = lvl_ok && (adx < {2'b00, rad_r}) && (ady < {2'b00, rad_r});
  end

  // Command sequencer
  always_comb begin
    st_nxt = st_r;       clr_nxt = clr_r;     sweep_nxt = sweep_r;
    count_nxt = count_r; idx_nxt = idx_r;     caddr_nxt = caddr_r;
    x_nxt = x_r;         y_nxt = y_r;         rad_nxt = rad_r;
    minl_nxt = minl_r;   maxl_nxt = maxl_r;   ix_nxt = ix_r;
    x1_nxt = x1_r;       iy_nxt = iy_r;       y0_nxt = y0_r;
    y1_nxt = y1_r;       p_nxt = p_r;         tail_nxt = tail_r;
    pend_nxt = pend_r;   n_nxt = n_r;         trunc_nxt = trunc_r;
    pend_v_nxt = pend_v_r;
    q_pop = 1'b0;  pt_we = 1'b0;  nx_we = 1'b0;  cl_we = 1'b0;
    emit = 1'b0;   e_status = ST_FILED;  e_idx = '0;  e_trunc = 1'b0;  e_last = 1'b1;
    adv = 1'b0;
    pt_raddr = p_r;  nx_waddr = c_tail;  cl_waddr = caddr_r;  cl_wdata = '0;
    cl_raddr = caddr_r;
    unique case (st_r)
      B_SWEEP: begin
        cl_we    = 1'b1;
        cl_waddr = sweep_r;
        if (sweep_r == NCW'(NCELL - 1)) begin
          if (!clr_r) begin
            st_nxt = B_IDLE;
          end else if (out_free) begin
            emit     = 1'b1;
            e_status = ST_CLEARED;
            st_nxt   = B_IDLE;
          end
        end else begin
          sweep_nxt = sweep_r + NCW'(1);
        end
      end
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_data.cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              sweep_nxt = '0;
              clr_nxt   = 1'b1;
              st_nxt    = B_SWEEP;
            end
            CMD_INSERT: begin
              if (count_r >= (IW+1)'(MAX_POINTS)) begin
                emit     = 1'b1;
                e_status = ST_FULL;
              end else begin
                pt_we     = 1'b1;
                count_nxt = count_r + 1'b1;
                idx_nxt   = count_r[IW-1:0];
                if (ins_ok) begin
                  caddr_nxt = ins_addr;
                  cl_raddr  = ins_addr;
                  st_nxt    = B_INS;
                end else begin
                  emit     = 1'b1;
                  e_status = ST_OUTSIDE;
                  e_idx    = count_r[IW-1:0];
                end
              end
            end
            CMD_QUERY: begin
              if (q_empty_rng) begin
                emit     = 1'b1;
                e_status = ST_NOHITS;
              end else begin
                x_nxt = q_data.x;  y_nxt = q_data.y;  rad_nxt = q_data.radius;
                minl_nxt = q_data.min_level;  maxl_nxt = q_data.max_level;
                ix_nxt = qx0;  x1_nxt = qx1;  iy_nxt = qy0;  y0_nxt = qy0;  y1_nxt = qy1;
                n_nxt = '0;  trunc_nxt = 1'b0;  pend_v_nxt = 1'b0;
                st_nxt = B_QCELL;
              end
            end
            default: st_nxt = B_IDLE;
          endcase
        end
      end
      B_INS: begin
        if (out_free) begin
          nx_we    = c_used;
          cl_we    = 1'b1;
          cl_wdata = {1'b1, (c_used ? c_head : idx_r), idx_r};
          emit     = 1'b1;
          e_status = ST_FILED;
          e_idx    = idx_r;
          st_nxt   = B_IDLE;
        end
      end
      B_QCELL: begin
        cl_raddr = q_addr;
        st_nxt   = B_QCWAIT;
      end
      B_QCWAIT: begin
        if (c_used) begin
          p_nxt    = c_head;
          tail_nxt = c_tail;
          pt_raddr = c_head;
          st_nxt   = B_QPT;
        end else begin
          adv = 1'b1;
        end
      end
      B_QPT: begin
        if (qual && (n_r == HW'(MAX_HITS))) begin
          trunc_nxt = 1'b1;
          st_nxt    = B_QEND;
        end else if (!(qual && pend_v_r && !out_free)) begin
          if (qual) begin
            if (pend_v_r) begin
              emit     = 1'b1;
              e_status = ST_HIT;
              e_idx    = pend_r;
              e_last   = 1'b0;
            end
            pend_nxt   = p_r;
            pend_v_nxt = 1'b1;
            n_nxt      = n_r + 1'b1;
          end
          if (p_r == tail_r) begin
            adv = 1'b1;
          end else begin
            p_nxt    = nx_rdata;
            pt_raddr = nx_rdata;
          end
        end
      end
      B_QEND: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_r) begin
            e_status = ST_HIT;
            e_idx    = pend_r;
            e_trunc  = trunc_r;
          end else begin
            e_status = ST_NOHITS;
          end
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase

    // Step to the next cell of the query window, row first
    if (adv) begin
      if (iy_r == y1_r) begin
        if (ix_r == x1_r) begin
          st_nxt = B_QEND;
        end else begin
          ix_nxt = ix_r + 1'b1;
          iy_nxt = y0_r;
          st_nxt = B_QCELL;
        end
      end else begin
        iy_nxt = iy_r + 1'b1;
        st_nxt = B_QCELL;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_SWEEP;
      clr_r    <= 1'b0;
      sweep_r  <= '0;
      count_r  <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      sweep_r  <= sweep_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;   caddr_r <= caddr_nxt;  x_r    <= x_nxt;    y_r  <= y_nxt;
    rad_r   <= rad_nxt;   minl_r  <= minl_nxt;   maxl_r <= maxl_nxt;
    ix_r    <= ix_nxt;    x1_r    <= x1_nxt;     iy_r   <= iy_nxt;
    y0_r    <= y0_nxt;    y1_r    <= y1_nxt;     p_r    <= p_nxt;
    tail_r  <= tail_nxt;  pend_r  <= pend_nxt;   n_r    <= n_nxt;
    trunc_r <= trunc_nxt;
    if (emit) begin
      out_st_r   <= e_status;
      out_idx_r  <= IDX_W'(e_idx);
      out_tr_r   <= e_trunc;
      out_last_r <= e_last;
    end
  end

endmodule
